// ===== design/drac_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drac_pkg
// shared widths, register map and mode codes of the rolling average contrast
// ----------------------------------------------------------------------------
package drac_pkg;

  localparam int unsigned PIX_W      = 16;  // sample and result width
  localparam int unsigned GAIN_W     = 17;  // gain_q8 width
  localparam int unsigned BATCH_W    = 7;   // batch_frames width
  localparam int unsigned SEL_W      = 2;   // output_select width
  localparam int unsigned FPIX_W     = 21;  // frame_pixels width
  localparam int unsigned QUO_W      = 17;  // quotient bits kept by the divider
  localparam int unsigned OFS_SHIFT  = 7;   // 32768 / 256
  localparam int unsigned DEN_SHIFT  = 8;   // gain fraction bits
  localparam int unsigned APB_AW     = 4;
  localparam int unsigned APB_DW     = 32;

  localparam logic [QUO_W-1:0] HALF_SCALE = QUO_W'(32768);
  localparam logic [PIX_W-1:0] FULL_SCALE = '1;

  localparam logic [BATCH_W-1:0] BATCH_RST = BATCH_W'(16);
  localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_W'(256);
  localparam logic [FPIX_W-1:0]  FPIX_RST  = FPIX_W'(1048576);

  typedef enum logic [1:0] {
    REG_BATCH  = 2'd0,
    REG_SELECT = 2'd1,
    REG_GAIN   = 2'd2,
    REG_PIXELS = 2'd3
  } reg_e;

  typedef enum logic [SEL_W-1:0] {
    MODE_OFFSET = 2'd0,
    MODE_ABS    = 2'd1,
    MODE_MEAN   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    PH_OLD    = 2'd0,
    PH_NEW    = 2'd1,
    PH_STEADY = 2'd2
  } phase_e;

  // per-pixel attributes that ride along the arithmetic pipeline
  typedef struct packed {
    logic             proc;
    logic             is8;
    logic             fend;
    logic             neg;
    logic [PIX_W-1:0] raw;
  } meta_t;

endpackage
`default_nettype wire

// ===== design/differential_rolling_average_contrast_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// differential_rolling_average_contrast_top
// per-pixel differential rolling average contrast over a raster stream
// ----------------------------------------------------------------------------
// usage
//   input channel: pixel_value_i, sample_is_8bit_i, restart_i with
//   in_valid_i / in_stall_o; a transfer happens when valid is high and stall
//   low. output channel: out_value_o, is_processed_o, out_is_8bit_o,
//   frame_end_o with out_valid_o / out_stall_i.
//   one pixel per cycle sustained while in_stall_o is low; every pixel
//   gives one result, through memory read, sum update, magnitude,
//   product and dividend setup, the restoring divider stages and the
//   output register.
//   the rate is set by the history memory (two reads and one write per
//   cycle) and the sum memory (one read and one write per cycle).
//   the whole pipeline moves as one; while the receiver stalls a full output
//   register, in_stall_o is high and every stage holds.
//   reset puts the registers to their reset values and empties the pipeline;
//   the per-pixel sums need no clearing pass, since the frame count marks
//   which sums are still unwritten, so pixels are taken right after reset.
//   the user writes the registers over the apb port only while the block is
//   idle (unchecked); a new batch size or frame size starts the history over.
// ----------------------------------------------------------------------------
module differential_rolling_average_contrast_top
  import drac_pkg::*;
#(
  parameter int unsigned MAX_BATCH  = 64,
  parameter int unsigned MAX_PIXELS = 1048576
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // pixel input
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [PIX_W-1:0]  pixel_value_i,
  input  wire logic              sample_is_8bit_i,
  input  wire logic              restart_i,
  // result output
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [PIX_W-1:0]       out_value_o,
  output logic                   is_processed_o,
  output logic                   out_is_8bit_o,
  output logic                   frame_end_o,
  // register port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  localparam int unsigned NB_W  = $clog2(MAX_BATCH + 1);
  localparam int unsigned FF_W  = NB_W + 1;
  localparam int unsigned SL_W  = $clog2(2 * MAX_BATCH);
  localparam int unsigned PC_W  = $clog2(MAX_PIXELS + 1);
  localparam int unsigned PO_W  = $clog2(MAX_PIXELS);
  localparam longint unsigned HD = 64'(2) * 64'(MAX_BATCH) * 64'(MAX_PIXELS);
  localparam int unsigned HA_W  = $clog2(HD);
  localparam int unsigned SUM_W = PIX_W + NB_W;
  localparam int unsigned PR_W  = SUM_W + GAIN_W;
  localparam int unsigned XW    = PR_W + PIX_W + 2;
  localparam int unsigned DW    = SUM_W + DEN_SHIFT + 1;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [BATCH_W-1:0] batch_q;
  logic [SEL_W-1:0]   select_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [FPIX_W-1:0]  fpix_q;
  logic               cfg_wr;
  logic               cfg_clear;
  reg_e               cfg_reg;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_reg = reg_e'(paddr[3:2]);

  // a new batch or frame size throws the history away
  always_comb begin
    cfg_clear = 1'b0;
    if (cfg_wr) begin
      case (cfg_reg)
        REG_BATCH:  cfg_clear = (pwdata[BATCH_W-1:0] != batch_q);
        REG_PIXELS: cfg_clear = (pwdata[FPIX_W-1:0] != fpix_q);
        default:    cfg_clear = 1'b0;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg)
      REG_BATCH:  prdata = APB_DW'(batch_q);
      REG_SELECT: prdata = APB_DW'(select_q);
      REG_GAIN:   prdata = APB_DW'(gain_q);
      REG_PIXELS: prdata = APB_DW'(fpix_q);
      default:    prdata = '0;
    endcase
  end

  // effective batch size and frame size
  logic [NB_W-1:0] n_eff;
  logic [FF_W-1:0] two_n;
  logic [PC_W-1:0] p_eff;

  always_comb begin
    n_eff = NB_W'(MAX_BATCH);
    if (batch_q == '0) begin
      n_eff = NB_W'(1);
    end else if (32'(batch_q) <= MAX_BATCH) begin
      n_eff = NB_W'(batch_q);
    end
    p_eff = PC_W'(MAX_PIXELS);
    if (fpix_q == '0) begin
      p_eff = PC_W'(1);
    end else if (32'(fpix_q) <= MAX_PIXELS) begin
      p_eff = PC_W'(fpix_q);
    end
  end

  assign two_n = {n_eff, 1'b0};

  // --------------------------------------------------------------------------
  // pipeline control
  // --------------------------------------------------------------------------
  logic en;
  logic accept;

  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;
  assign accept     = in_valid_i && en;

  // --------------------------------------------------------------------------
  // frame position bookkeeping at the input transfer
  // --------------------------------------------------------------------------
  logic [PO_W-1:0] pos_q;
  logic [SL_W-1:0] slot_q;
  logic [FF_W-1:0] ff_q;

  logic [PO_W-1:0] pos_a;
  logic [SL_W-1:0] slot_a;
  logic [SL_W-1:0] bslot_a;
  logic [FF_W-1:0] ff_a;
  logic [FF_W-1:0] bsum;
  logic [HA_W-1:0] addr0_a;
  logic [HA_W-1:0] addr1_a;
  phase_e          phase_a;
  logic            proc_a;
  logic            last_a;
  logic [PIX_W-1:0] raw_a;
  logic [PIX_W-1:0] x_a;

  always_comb begin
    // restart acts as if history had just been cleared
    pos_a  = restart_i ? '0 : pos_q;
    slot_a = restart_i ? '0 : slot_q;
    ff_a   = restart_i ? '0 : ff_q;
    if (PC_W'(pos_a) >= p_eff) begin
      pos_a = '0;
    end
    if (FF_W'(slot_a) >= two_n) begin
      slot_a = '0;
    end
    // bridge slot: the frame moving from the newer to the older average
    bsum = FF_W'(slot_a) + FF_W'(n_eff);
    if (bsum >= two_n) begin
      bsum = bsum - two_n;
    end
    bslot_a = SL_W'(bsum);
    addr0_a = HA_W'(slot_a) * HA_W'(MAX_PIXELS) + HA_W'(pos_a);
    addr1_a = HA_W'(bslot_a) * HA_W'(MAX_PIXELS) + HA_W'(pos_a);
    if (ff_a < FF_W'(n_eff)) begin
      phase_a = PH_OLD;
    end else if (ff_a < two_n) begin
      phase_a = PH_NEW;
    end else begin
      phase_a = PH_STEADY;
    end
    proc_a = (phase_a == PH_STEADY) || (ff_a == two_n - FF_W'(1));
    last_a = (PC_W'(pos_a) + PC_W'(1)) >= p_eff;
    // an 8-bit sample keeps its low byte; times 257 is the byte doubled
    raw_a = sample_is_8bit_i ? {8'd0, pixel_value_i[7:0]} : pixel_value_i;
    x_a   = sample_is_8bit_i ? {pixel_value_i[7:0], pixel_value_i[7:0]} : pixel_value_i;
  end

  // --------------------------------------------------------------------------
  // stage b: sum update after the memory read
  // --------------------------------------------------------------------------
  logic             b_valid_q;
  logic [PO_W-1:0]  b_pos_q;
  logic [HA_W-1:0]  b_addr_q;
  logic [PIX_W-1:0] b_x_q;
  logic [PIX_W-1:0] b_raw_q;
  logic             b_is8_q;
  logic             b_fend_q;
  logic             b_proc_q;
  phase_e           b_phase_q;
  logic             b_zold_q;
  logic             b_znew_q;
  logic             b_fs_q;
  logic             b_fh0_q;
  logic             b_fh1_q;

  logic [2*SUM_W-1:0] sums_rd_q;
  logic [PIX_W-1:0]   h0_rd_q;
  logic [PIX_W-1:0]   h1_rd_q;
  logic [2*SUM_W-1:0] fwd_sums_q;
  logic [PIX_W-1:0]   fwd_hist_q;

  logic [2*SUM_W-1:0] sum_mem [MAX_PIXELS];
  logic [PIX_W-1:0]   hist_mem [HD];

  logic [SUM_W-1:0] a_old;
  logic [SUM_W-1:0] b_old;
  logic [PIX_W-1:0] oldest;
  logic [PIX_W-1:0] bridge;
  logic [SUM_W-1:0] a_new;
  logic [SUM_W-1:0] b_new;
  logic             b_wr;

  assign b_wr = en && b_valid_q;

  always_comb begin
    // a sum not yet touched since the last clear reads as zero
    if (b_zold_q) begin
      a_old = '0;
    end else if (b_fs_q) begin
      a_old = fwd_sums_q[2*SUM_W-1:SUM_W];
    end else begin
      a_old = sums_rd_q[2*SUM_W-1:SUM_W];
    end
    if (b_znew_q) begin
      b_old = '0;
    end else if (b_fs_q) begin
      b_old = fwd_sums_q[SUM_W-1:0];
    end else begin
      b_old = sums_rd_q[SUM_W-1:0];
    end
    oldest = b_fh0_q ? fwd_hist_q : h0_rd_q;
    bridge = b_fh1_q ? fwd_hist_q : h1_rd_q;
    case (b_phase_q)
      PH_OLD: begin
        a_new = a_old + SUM_W'(b_x_q);
        b_new = b_old;
      end
      PH_NEW: begin
        a_new = a_old;
        b_new = b_old + SUM_W'(b_x_q);
      end
      default: begin
        a_new = a_old + SUM_W'(bridge) - SUM_W'(oldest);
        b_new = b_old + SUM_W'(b_x_q) - SUM_W'(bridge);
      end
    endcase
  end

  // sum memory: one read, one write per cycle
  always_ff @(posedge clk_i) begin
    if (b_wr) begin
      sum_mem[b_pos_q] <= {a_new, b_new};
    end
    if (accept) begin
      sums_rd_q <= sum_mem[pos_a];
    end
  end

  // history memory: two reads, one write per cycle
  always_ff @(posedge clk_i) begin
    if (b_wr) begin
      hist_mem[b_addr_q] <= b_x_q;
    end
    if (accept) begin
      h0_rd_q <= hist_mem[addr0_a];
      h1_rd_q <= hist_mem[addr1_a];
    end
  end

  // --------------------------------------------------------------------------
  // arithmetic pipeline registers
  // --------------------------------------------------------------------------
  logic             c_valid_q;
  meta_t            c_meta_q;
  logic [SUM_W-1:0] c_a_q;
  logic [SUM_W-1:0] c_b_q;

  logic             d_valid_q;
  meta_t            d_meta_q;
  logic [SUM_W-1:0] d_ad_q;
  logic [SUM_W-1:0] d_m_q;
  logic [SUM_W-1:0] d_a_q;

  logic             e_valid_q;
  meta_t            e_meta_q;
  logic [PR_W-1:0]  e_prod_q;
  logic [SUM_W-1:0] e_m_q;
  logic [SUM_W-1:0] e_a_q;

  logic             f_valid_q;
  meta_t            f_meta_q;
  logic [XW-1:0]    f_x_q;
  logic [DW-1:0]    f_dd_q;

  logic [QUO_W:0]   dv_valid_q;
  meta_t            dv_meta_q [QUO_W+1];
  logic [XW-1:0]    dv_rem_q  [QUO_W+1];
  logic [DW-1:0]    dv_dd_q   [QUO_W+1];
  logic [QUO_W-1:0] dv_quo_q  [QUO_W+1];
  logic             dv_ovf_q  [QUO_W+1];

  meta_t            b_meta;
  meta_t            c_meta;
  logic [SUM_W-1:0] n_sum;
  logic [SUM_W-1:0] ad_c;
  logic [SUM_W-1:0] m_c;
  logic             neg_c;
  mode_e            mode;
  logic [XW-1:0]    num_e;
  logic [XW-1:0]    den_e;
  logic             ovf_f;

  assign mode  = mode_e'(select_q);
  assign n_sum = SUM_W'(n_eff);

  always_comb begin
    b_meta      = '0;
    b_meta.proc = b_proc_q;
    b_meta.is8  = b_is8_q;
    b_meta.fend = b_fend_q;
    b_meta.raw  = b_raw_q;
  end

  // magnitude and sign of the difference, and the divisor max(older, n)
  always_comb begin
    neg_c      = c_b_q < c_a_q;
    ad_c       = neg_c ? (c_a_q - c_b_q) : (c_b_q - c_a_q);
    m_c        = (c_a_q > n_sum) ? c_a_q : n_sum;
    c_meta     = c_meta_q;
    c_meta.neg = neg_c;
  end

  // dividend and divisor; the quotient is round(num / den) with halves up
  always_comb begin
    case (mode)
      MODE_OFFSET: begin
        num_e = XW'(e_prod_q) << OFS_SHIFT;
        den_e = XW'(e_m_q);
      end
      MODE_ABS: begin
        num_e = (XW'(e_prod_q) << PIX_W) - XW'(e_prod_q);
        den_e = XW'(e_m_q) << DEN_SHIFT;
      end
      MODE_MEAN: begin
        num_e = XW'(e_a_q);
        den_e = XW'(n_sum);
      end
      default: begin
        num_e = XW'(e_a_q);
        den_e = XW'(n_sum);
      end
    endcase
  end

  assign ovf_f = (f_x_q >> QUO_W) >= XW'(f_dd_q);

  // restoring divider, one quotient bit per stage
  logic [XW-1:0]    dv_rem_n [QUO_W];
  logic [QUO_W-1:0] dv_quo_n [QUO_W];

  always_comb begin
    for (int j = 0; j < QUO_W; j++) begin
      logic [XW-1:0] sub;
      sub         = XW'(dv_dd_q[j]) << (QUO_W - 1 - j);
      dv_rem_n[j] = dv_rem_q[j];
      dv_quo_n[j] = dv_quo_q[j];
      if (dv_rem_q[j] >= sub) begin
        dv_rem_n[j]              = dv_rem_q[j] - sub;
        dv_quo_n[j][QUO_W-1-j]   = 1'b1;
      end
    end
  end

  // final rounding fix and saturation
  logic [QUO_W-1:0] quo;
  logic [QUO_W-1:0] mag;
  logic             ovf;
  meta_t            fin_meta;
  logic [PIX_W-1:0] fin_value;

  always_comb begin
    quo      = dv_quo_q[QUO_W];
    ovf      = dv_ovf_q[QUO_W];
    fin_meta = dv_meta_q[QUO_W];
    // on a negative exact half the rounding goes toward zero magnitude
    mag = (dv_rem_q[QUO_W] == '0) ? (quo - QUO_W'(1)) : quo;
    if (!fin_meta.proc) begin
      fin_value = fin_meta.raw;
    end else begin
      case (mode)
        MODE_OFFSET: begin
          if (fin_meta.neg) begin
            fin_value = (ovf || (mag > HALF_SCALE)) ? '0 : PIX_W'(HALF_SCALE - mag);
          end else begin
            fin_value = (ovf || (quo >= HALF_SCALE)) ? FULL_SCALE :
                        PIX_W'(HALF_SCALE + quo);
          end
        end
        default: begin
          fin_value = (ovf || quo[QUO_W-1]) ? FULL_SCALE : quo[PIX_W-1:0];
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_q     <= BATCH_RST;
      select_q    <= '0;
      gain_q      <= GAIN_RST;
      fpix_q      <= FPIX_RST;
      pos_q       <= '0;
      slot_q      <= '0;
      ff_q        <= '0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      d_valid_q   <= 1'b0;
      e_valid_q   <= 1'b0;
      f_valid_q   <= 1'b0;
      dv_valid_q  <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_clear) begin
        pos_q  <= '0;
        slot_q <= '0;
        ff_q   <= '0;
      end else if (accept) begin
        if (last_a) begin
          pos_q  <= '0;
          slot_q <= ((FF_W'(slot_a) + FF_W'(1)) >= two_n) ? '0 : slot_a + SL_W'(1);
          ff_q   <= (ff_a < two_n) ? ff_a + FF_W'(1) : ff_a;
        end else begin
          pos_q  <= pos_a + PO_W'(1);
          slot_q <= slot_a;
          ff_q   <= ff_a;
        end
      end
      if (cfg_wr) begin
        case (cfg_reg)
          REG_BATCH:  batch_q  <= pwdata[BATCH_W-1:0];
          REG_SELECT: select_q <= pwdata[SEL_W-1:0];
          REG_GAIN:   gain_q   <= pwdata[GAIN_W-1:0];
          REG_PIXELS: fpix_q   <= pwdata[FPIX_W-1:0];
          default:    select_q <= select_q;
        endcase
      end
      if (en) begin
        b_valid_q   <= in_valid_i;
        c_valid_q   <= b_valid_q;
        d_valid_q   <= c_valid_q;
        e_valid_q   <= d_valid_q;
        f_valid_q   <= e_valid_q;
        dv_valid_q  <= {dv_valid_q[QUO_W-1:0], f_valid_q};
        out_valid_o <= dv_valid_q[QUO_W];
      end
    end
  end

  // --------------------------------------------------------------------------
  // payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (accept) begin
        b_pos_q   <= pos_a;
        b_addr_q  <= addr0_a;
        b_x_q     <= x_a;
        b_raw_q   <= raw_a;
        b_is8_q   <= sample_is_8bit_i;
        b_fend_q  <= last_a;
        b_proc_q  <= proc_a;
        b_phase_q <= phase_a;
        b_zold_q  <= (ff_a == '0);
        b_znew_q  <= (ff_a == FF_W'(n_eff));
        // the pixel in stage b writes at this edge; pass its data on
        b_fs_q    <= b_valid_q && (pos_a == b_pos_q);
        b_fh0_q   <= b_valid_q && (addr0_a == b_addr_q);
        b_fh1_q   <= b_valid_q && (addr1_a == b_addr_q);
      end
      fwd_sums_q <= {a_new, b_new};
      fwd_hist_q <= b_x_q;

      c_meta_q <= b_meta;
      c_a_q    <= a_new;
      c_b_q    <= b_new;

      d_meta_q     <= c_meta;
      d_ad_q       <= ad_c;
      d_m_q        <= m_c;
      d_a_q        <= c_a_q;

      e_meta_q <= d_meta_q;
      e_prod_q <= PR_W'(d_ad_q) * PR_W'(gain_q);
      e_m_q    <= d_m_q;
      e_a_q    <= d_a_q;

      f_meta_q <= e_meta_q;
      f_x_q    <= (num_e << 1) + den_e;
      f_dd_q   <= DW'(den_e << 1);

      dv_meta_q[0] <= f_meta_q;
      dv_rem_q[0]  <= f_x_q;
      dv_dd_q[0]   <= f_dd_q;
      dv_quo_q[0]  <= '0;
      dv_ovf_q[0]  <= ovf_f;
      for (int j = 0; j < QUO_W; j++) begin
        dv_meta_q[j+1] <= dv_meta_q[j];
        dv_rem_q[j+1]  <= dv_rem_n[j];
        dv_dd_q[j+1]   <= dv_dd_q[j];
        dv_quo_q[j+1]  <= dv_quo_n[j];
        dv_ovf_q[j+1]  <= dv_ovf_q[j];
      end

      out_value_o    <= fin_value;
      is_processed_o <= fin_meta.proc;
      out_is_8bit_o  <= fin_meta.proc ? 1'b0 : fin_meta.is8;
      frame_end_o    <= fin_meta.fend;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  a_frames_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ff_q <= two_n)
    else $error("frame count beyond twice the batch");

  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    FF_W'(slot_q) < two_n)
    else $error("ring slot beyond twice the batch");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    PC_W'(pos_q) < p_eff)
    else $error("pixel position beyond frame size");

  a_zero_old_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && b_zold_q) |-> (b_phase_q == PH_OLD))
    else $error("first frame not in older fill phase");

  a_proc_in_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (phase_a == PH_STEADY)) |=> (b_valid_q && b_proc_q))
    else $error("steady pixel lost its processed flag");
`endif

endmodule
`default_nettype wire
